### rtl/circular_range_arithmetic_macros.svh
// assertion macros used by the checker file of the circular range arithmetic block
`ifndef CIRCULAR_RANGE_ARITHMETIC_MACROS_SVH
`define CIRCULAR_RANGE_ARITHMETIC_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define CRA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("circular range arithmetic check failed");

// next-cycle implication, disabled while reset is low
`define CRA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("circular range arithmetic check failed");

`endif

### rtl/cra_pkg.sv
// shared constants and codes of the circular range arithmetic block
package cra_pkg;

    // default value width
    localparam int VALUE_WIDTH_DEF = 16;

    // request codes
    localparam int REQ_W = 3;
    localparam logic [REQ_W-1:0] REQ_ASSIGN = 3'd0;
    localparam logic [REQ_W-1:0] REQ_ADD    = 3'd1;
    localparam logic [REQ_W-1:0] REQ_SUB    = 3'd2;
    localparam logic [REQ_W-1:0] REQ_MUL    = 3'd3;
    localparam logic [REQ_W-1:0] REQ_DIV    = 3'd4;
    localparam logic [REQ_W-1:0] REQ_INC    = 3'd5;
    localparam logic [REQ_W-1:0] REQ_DEC    = 3'd6;
    localparam logic [REQ_W-1:0] REQ_READ   = 3'd7;

    // configuration register indexes
    localparam int CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] REG_RANGE_LOW  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_RANGE_HIGH = 2'd1;

    // reset values
    localparam int RESET_LOW   = 1;
    localparam int RESET_HIGH  = 12;
    localparam int RESET_VALUE = 1;

endpackage

### rtl/cra_rem_unit.sv
// bit-serial non-negative remainder of a signed dividend by the range period
module cra_rem_unit #(
    parameter int VALUE_WIDTH = cra_pkg::VALUE_WIDTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic [2*VALUE_WIDTH:0]   i_dividend,
    input  logic [VALUE_WIDTH:0]     i_period,
    output logic                     o_done,
    output logic [VALUE_WIDTH-1:0]   o_rem
);
    import cra_pkg::*;

    localparam int DW    = 2 * VALUE_WIDTH + 1;
    localparam int CNT_W = $clog2(DW);
    localparam logic [CNT_W-1:0] LAST_BIT = CNT_W'(DW - 1);

    localparam logic [2:0] U_IDLE  = 3'd0;
    localparam logic [2:0] U_ABS   = 3'd1;
    localparam logic [2:0] U_SHIFT = 3'd2;
    localparam logic [2:0] U_FIX   = 3'd3;
    localparam logic [2:0] U_DONE  = 3'd4;

    logic [2:0]             r_state;
    logic [DW-1:0]          r_mag;
    logic                   r_neg;
    logic [VALUE_WIDTH-1:0] r_part;
    logic [CNT_W-1:0]       r_cnt;

    logic [VALUE_WIDTH:0]   trial;
    logic                   trial_ge;
    logic [VALUE_WIDTH-1:0] n_part;

    // one restoring step: bring down the next bit, subtract the period if it fits
    always_comb begin
        trial    = {r_part, r_mag[DW-1]};
        trial_ge = (trial >= i_period);
        n_part   = trial_ge ? VALUE_WIDTH'(trial - i_period) : trial[VALUE_WIDTH-1:0];
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= U_IDLE;
        end else begin
            unique case (r_state)
                U_IDLE:  if (i_start) r_state <= U_ABS;
                U_ABS:   r_state <= U_SHIFT;
                U_SHIFT: if (r_cnt == '0) r_state <= U_FIX;
                U_FIX:   r_state <= U_DONE;
                U_DONE:  r_state <= U_IDLE;
                default: r_state <= U_IDLE;
            endcase
        end
    end

    // datapath: magnitude, partial remainder, bit counter
    always_ff @(posedge i_clk) begin
        case (r_state)
            U_IDLE: begin
                if (i_start) r_mag <= i_dividend;
            end
            U_ABS: begin
                r_neg  <= r_mag[DW-1];
                r_mag  <= r_mag[DW-1] ? -r_mag : r_mag;
                r_part <= '0;
                r_cnt  <= LAST_BIT;
            end
            U_SHIFT: begin
                r_part <= n_part;
                r_mag  <= {r_mag[DW-2:0], 1'b0};
                r_cnt  <= r_cnt - 1'b1;
            end
            U_FIX: begin
                // negative dividend: fold the remainder back to the non-negative side
                if (r_neg && (r_part != '0)) begin
                    r_part <= VALUE_WIDTH'(i_period - {1'b0, r_part});
                end
            end
            default: ;
        endcase
    end

    assign o_done = (r_state == U_DONE);
    assign o_rem  = r_part;

endmodule

### rtl/circular_range_arithmetic.sv
// Circular range arithmetic unit: holds one value wrapped into [lo, hi], where lo and hi
// are the ordered ends from the two range registers, and applies one request per input
// beat, returning the new and the prior value. All wrapping goes through one bit-serial
// remainder unit that retires one dividend bit per cycle over 2*VALUE_WIDTH+1 bits, so a
// request is held while the unit runs and the input stalls meanwhile. Read skips the
// remainder unit and goes from accept to the result register; assign, add, sub, inc and
// dec run one reduction; mul first forms the product in the product register.
// Divide runs two reductions (operand and lo*operand - lo) and then checks one candidate
// per cycle from lo upward, at most hi-lo+1 of them. The input is free again the cycle
// after the result register loads; a stalled result beat holds the request until the
// result register can take it. A write to either range register moves the value to the
// new lower end; write registers only while no request is in progress.
module circular_range_arithmetic #(
    parameter int VALUE_WIDTH = cra_pkg::VALUE_WIDTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // request channel
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [cra_pkg::REQ_W-1:0]         i_req_type,
    input  logic signed [VALUE_WIDTH-1:0]     i_operand,
    // result channel
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic signed [VALUE_WIDTH-1:0]     o_new_value,
    output logic signed [VALUE_WIDTH-1:0]     o_prior_value,
    output logic                              o_no_quotient,
    // configuration write port
    input  logic                              i_cfg_we,
    input  logic [cra_pkg::CFG_INDEX_W-1:0]   i_cfg_index,
    input  logic [VALUE_WIDTH-1:0]            i_cfg_data
);
    import cra_pkg::*;

    localparam int W  = VALUE_WIDTH;
    localparam int DW = 2 * VALUE_WIDTH + 1;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL  = 3'd1;
    localparam logic [2:0] S_FORM = 3'd2;
    localparam logic [2:0] S_WAIT = 3'd3;
    localparam logic [2:0] S_SRCH = 3'd4;
    localparam logic [2:0] S_DONE = 3'd5;

    // control state
    logic [2:0]            r_state;
    logic                  r_phase;
    logic                  r_out_valid;
    logic signed [W-1:0]   r_reg_low;
    logic signed [W-1:0]   r_reg_high;
    logic signed [W-1:0]   r_cur;

    // request datapath
    logic [REQ_W-1:0]      r_req;
    logic signed [W-1:0]   r_op;
    logic signed [W-1:0]   r_prior;
    logic signed [2*W-1:0] r_prod;
    logic [W-1:0]          r_s;
    logic [W-1:0]          r_y;
    logic [W-1:0]          r_tgt;
    logic [W-1:0]          r_cnt;
    logic signed [W-1:0]   r_next;
    logic                  r_fail;

    // result register
    logic signed [W-1:0]   r_out_new;
    logic signed [W-1:0]   r_out_prior;
    logic                  r_out_nq;

    logic signed [W-1:0]   lo;
    logic signed [W-1:0]   hi;
    logic [W-1:0]          span;
    logic [W:0]            period;
    logic signed [W-1:0]   cfg_low;
    logic signed [W-1:0]   cfg_high;
    logic signed [W-1:0]   cfg_lo;
    logic signed [W-1:0]   mul_a;
    logic signed [DW-1:0]  form_a;
    logic signed [DW-1:0]  form_dvd;
    logic [W:0]            y_sum;
    logic [W-1:0]          n_y;
    logic                  in_beat;
    logic                  out_free;
    logic                  rem_start;
    logic                  rem_done;
    logic [W-1:0]          rem_val;

    // ordered range ends and period
    always_comb begin
        lo     = (r_reg_low < r_reg_high) ? r_reg_low : r_reg_high;
        hi     = (r_reg_low < r_reg_high) ? r_reg_high : r_reg_low;
        span   = W'(hi - lo);
        period = {1'b0, span} + 1'b1;
    end

    // lower end after a register write
    always_comb begin
        cfg_low  = (i_cfg_index == REG_RANGE_LOW)  ? i_cfg_data : r_reg_low;
        cfg_high = (i_cfg_index == REG_RANGE_HIGH) ? i_cfg_data : r_reg_high;
        cfg_lo   = (cfg_low < cfg_high) ? cfg_low : cfg_high;
    end

    // dividend for the remainder unit, offset by the lower end
    always_comb begin
        mul_a  = (r_req == REQ_DIV) ? lo : r_prior;
        form_a = DW'(r_op);
        case (r_req)
            REQ_ADD: form_a = DW'(r_prior) + DW'(r_op);
            REQ_SUB: form_a = DW'(r_prior) - DW'(r_op);
            REQ_INC: form_a = DW'(r_prior) + DW'(1);
            REQ_DEC: form_a = DW'(r_prior) - DW'(1);
            REQ_MUL: form_a = DW'(r_prod);
            REQ_DIV: form_a = r_phase ? DW'(r_prod) : DW'(r_op);
            default: form_a = DW'(r_op);
        endcase
        // operand residue for divide is taken without the offset
        if ((r_req == REQ_DIV) && !r_phase) begin
            form_dvd = form_a;
        end else begin
            form_dvd = form_a - DW'(lo);
        end
    end

    // next residue of x*operand - lo when x steps up by one
    always_comb begin
        y_sum = {1'b0, r_y} + {1'b0, r_s};
        n_y   = (y_sum >= period) ? W'(y_sum - period) : y_sum[W-1:0];
    end

    assign in_beat   = i_in_valid && (r_state == S_IDLE);
    assign out_free  = !r_out_valid || !i_out_stall;
    assign rem_start = (r_state == S_FORM);

    cra_rem_unit #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_rem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (rem_start),
        .i_dividend (form_dvd),
        .i_period   (period),
        .o_done     (rem_done),
        .o_rem      (rem_val)
    );

    // sequencer, range registers and held value
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_phase     <= 1'b0;
            r_out_valid <= 1'b0;
            r_reg_low   <= W'(RESET_LOW);
            r_reg_high  <= W'(RESET_HIGH);
            r_cur       <= W'(RESET_VALUE);
        end else begin
            if (r_out_valid && !i_out_stall) r_out_valid <= 1'b0;

            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    REG_RANGE_LOW: begin
                        r_reg_low <= i_cfg_data;
                        r_cur     <= cfg_lo;
                    end
                    REG_RANGE_HIGH: begin
                        r_reg_high <= i_cfg_data;
                        r_cur      <= cfg_lo;
                    end
                    default: ;
                endcase
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_beat) begin
                        r_phase <= 1'b0;
                        case (i_req_type) inside
                            REQ_READ:         r_state <= S_DONE;
                            REQ_MUL, REQ_DIV: r_state <= S_MUL;
                            default:          r_state <= S_FORM;
                        endcase
                    end
                end
                S_MUL:  r_state <= S_FORM;
                S_FORM: r_state <= S_WAIT;
                S_WAIT: begin
                    if (rem_done) begin
                        if ((r_req == REQ_DIV) && !r_phase) begin
                            r_phase <= 1'b1;
                            r_state <= S_FORM;
                        end else if (r_req == REQ_DIV) begin
                            r_state <= S_SRCH;
                        end else begin
                            r_state <= S_DONE;
                        end
                    end
                end
                S_SRCH: begin
                    if ((r_y == r_tgt) || (r_cnt == span)) r_state <= S_DONE;
                end
                S_DONE: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_cur       <= r_next;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // request datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (in_beat) begin
                    r_req   <= i_req_type;
                    r_op    <= i_operand;
                    r_prior <= r_cur;
                    r_next  <= r_cur;
                    r_fail  <= 1'b0;
                end
            end
            S_MUL: begin
                r_prod <= mul_a * r_op;
            end
            S_WAIT: begin
                if (rem_done) begin
                    if ((r_req == REQ_DIV) && !r_phase) begin
                        r_s <= rem_val;
                    end else if (r_req == REQ_DIV) begin
                        r_y   <= rem_val;
                        r_cnt <= '0;
                        r_tgt <= W'(r_prior - lo);
                    end else begin
                        r_next <= lo + rem_val;
                    end
                end
            end
            S_SRCH: begin
                // candidate x = lo + r_cnt, residue of x*operand - lo in r_y
                if (r_y == r_tgt) begin
                    r_next <= lo + r_cnt;
                    r_fail <= 1'b0;
                end else if (r_cnt == span) begin
                    r_next <= r_prior;
                    r_fail <= 1'b1;
                end else begin
                    r_cnt <= r_cnt + 1'b1;
                    r_y   <= n_y;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    r_out_new   <= r_next;
                    r_out_prior <= r_prior;
                    r_out_nq    <= r_fail;
                end
            end
            default: ;
        endcase
    end

    assign o_in_stall    = (r_state != S_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_new_value   = r_out_new;
    assign o_prior_value = r_out_prior;
    assign o_no_quotient = r_out_nq;

endmodule

### rtl/cra_checker.sv
// port-level checks of the circular range arithmetic block and their bind
`include "circular_range_arithmetic_macros.svh"

module cra_checker #(
    parameter int VALUE_WIDTH = cra_pkg::VALUE_WIDTH_DEF
) (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          o_in_stall,
    input logic                          o_out_valid,
    input logic                          i_out_stall,
    input logic signed [VALUE_WIDTH-1:0] o_new_value,
    input logic signed [VALUE_WIDTH-1:0] o_prior_value,
    input logic                          o_no_quotient
);

    // a request beat keeps the block busy for at least the next cycle
    `CRA_ASSERT_NEXT(a_busy_after_req, i_clk, i_rst_n,
        i_in_valid && !o_in_stall, o_in_stall)

    // a failed divide leaves the value unchanged
    `CRA_ASSERT_NOW(a_nq_keeps_value, i_clk, i_rst_n,
        o_out_valid && o_no_quotient, o_new_value == o_prior_value)

    // a stalled result beat stays offered
    `CRA_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid)

    // a stalled result beat keeps its payload
    `CRA_ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, o_out_valid && i_out_stall,
        $stable(o_new_value) && $stable(o_prior_value) && $stable(o_no_quotient))

endmodule

bind circular_range_arithmetic cra_checker #(.VALUE_WIDTH(VALUE_WIDTH)) u_cra_checker (.*);
